// ===== src/exptok_pkg.sv =====
// Shared types, codes and helpers for the expression tokenizer.
// No dependencies; used by every module of the block.
package exptok_pkg;

  localparam int VALUE_WIDTH_DEF = 32;
  localparam int OUT_VALUE_W     = 32;

  // lexer mode, one-hot
  typedef enum logic [9:0] {
    MODE_IDLE    = 10'b00_0000_0001,
    MODE_NUMBER  = 10'b00_0000_0010,
    MODE_LT      = 10'b00_0000_0100,
    MODE_GT      = 10'b00_0000_1000,
    MODE_AMP     = 10'b00_0001_0000,
    MODE_EQ      = 10'b00_0010_0000,
    MODE_PIPE    = 10'b00_0100_0000,
    MODE_BANG    = 10'b00_1000_0000,
    MODE_KEYWORD = 10'b01_0000_0000,
    MODE_ERROR   = 10'b10_0000_0000
  } mode_t;

  typedef enum logic [3:0] {
    KIND_LIT    = 4'd0,
    KIND_ADD    = 4'd1,
    KIND_MUL    = 4'd2,
    KIND_REL    = 4'd3,
    KIND_AND    = 4'd4,
    KIND_EQU    = 4'd5,
    KIND_OR     = 4'd6,
    KIND_LPAREN = 4'd7,
    KIND_RPAREN = 4'd8,
    KIND_EOF    = 4'd9,
    KIND_ERROR  = 4'd10
  } kind_t;

  typedef enum logic [2:0] {
    ERR_NONE      = 3'd0,
    ERR_BAD_CHAR  = 3'd1,
    ERR_WANT_AND  = 3'd2,
    ERR_WANT_EQ   = 3'd3,
    ERR_WANT_OR   = 3'd4,
    ERR_WANT_NE   = 3'd5,
    ERR_WANT_TRUE = 3'd6,
    ERR_WANT_FALSE = 3'd7
  } err_t;

  localparam logic [1:0] VAR_NONE  = 2'd0;
  localparam logic [1:0] VAR_INT   = 2'd0;
  localparam logic [1:0] VAR_TRUE  = 2'd1;
  localparam logic [1:0] VAR_FALSE = 2'd2;
  localparam logic [1:0] VAR_PLUS  = 2'd0;
  localparam logic [1:0] VAR_MINUS = 2'd1;
  localparam logic [1:0] VAR_TIMES = 2'd0;
  localparam logic [1:0] VAR_DIV   = 2'd1;
  localparam logic [1:0] VAR_LT    = 2'd0;
  localparam logic [1:0] VAR_LE    = 2'd1;
  localparam logic [1:0] VAR_GT    = 2'd2;
  localparam logic [1:0] VAR_GE    = 2'd3;
  localparam logic [1:0] VAR_EQ    = 2'd0;
  localparam logic [1:0] VAR_NE    = 2'd1;

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_BANG   = 8'h21;
  localparam logic [7:0] CH_AMP    = 8'h26;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_LESS   = 8'h3C;
  localparam logic [7:0] CH_EQUAL  = 8'h3D;
  localparam logic [7:0] CH_GREAT  = 8'h3E;
  localparam logic [7:0] CH_A      = 8'h61;
  localparam logic [7:0] CH_E      = 8'h65;
  localparam logic [7:0] CH_F      = 8'h66;
  localparam logic [7:0] CH_L      = 8'h6C;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_S      = 8'h73;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_U      = 8'h75;
  localparam logic [7:0] CH_PIPE   = 8'h7C;

  localparam logic [2:0] LEN_TRUE  = 3'd4;
  localparam logic [2:0] LEN_FALSE = 3'd5;

  typedef struct packed {
    kind_t                    kind;
    logic [1:0]               variant;
    logic [OUT_VALUE_W-1:0]   value;
    logic                     overflow;
    err_t                     error_code;
    logic                     last;
  } token_t;

  function automatic token_t make_tok(input kind_t k, input logic [1:0] v,
                                      input logic [OUT_VALUE_W-1:0] val,
                                      input logic ovf, input err_t e);
    token_t t;
    t.kind       = k;
    t.variant    = v;
    t.value      = val;
    t.overflow   = ovf;
    t.error_code = e;
    t.last       = 1'b0;
    return t;
  endfunction

  // expected byte at a given position of "true" / "false"
  function automatic logic [7:0] keyword_char(input logic is_false,
                                              input logic [2:0] pos);
    logic [7:0] c;
    c = CH_E;
    if (is_false) begin
      case (pos)
        3'd0: c = CH_F;
        3'd1: c = CH_A;
        3'd2: c = CH_L;
        3'd3: c = CH_S;
        default: c = CH_E;
      endcase
    end else begin
      case (pos)
        3'd0: c = CH_T;
        3'd1: c = CH_R;
        3'd2: c = CH_U;
        default: c = CH_E;
      endcase
    end
    return c;
  endfunction

endpackage

// ===== src/exptok_lexer.sv =====
// Lexer state and next-state / token logic for one byte per step.
// Depends on exptok_pkg.
module exptok_lexer #(
  parameter int VALUE_WIDTH = exptok_pkg::VALUE_WIDTH_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  logic [7:0]        ch,
  input  logic              at_end,
  output logic [1:0]        count,
  output exptok_pkg::token_t res0,
  output exptok_pkg::token_t res1
);
  import exptok_pkg::*;

  mode_t                  mode, mode_next;
  logic [VALUE_WIDTH-1:0] acc, acc_next;
  logic                   sat, sat_next;
  logic [2:0]             kpos, kpos_next;
  logic                   kmis, kmis_next;
  logic                   kfalse, kfalse_next;

  logic                   is_space, is_digit;
  logic [VALUE_WIDTH+3:0] prod;
  logic                   prod_ovf;

  // fresh lex of the current byte
  logic   f_emit, f_num, f_kw;
  token_t f_tok;
  mode_t  f_mode;

  // token closed by the pending mode, and a second token
  logic   c_emit, s_emit, use_fresh;
  token_t c_tok, s_tok;

  logic       kmis_w;
  logic [2:0] kpos_w, klen;
  err_t       kerr;

  assign is_space = (ch == CH_SPACE) || (ch >= CH_TAB && ch <= CH_CR);
  assign is_digit = (ch >= CH_ZERO) && (ch <= CH_NINE);
  assign prod = ({4'b0, acc} << 3) + ({4'b0, acc} << 1)
              + (VALUE_WIDTH+4)'(ch[3:0]);
  assign prod_ovf = (prod[VALUE_WIDTH+3:VALUE_WIDTH] != 4'd0);

  always_comb begin
    f_emit = 1'b0;
    f_num  = 1'b0;
    f_kw   = 1'b0;
    f_tok  = make_tok(KIND_EOF, VAR_NONE, '0, 1'b0, ERR_NONE);
    f_mode = MODE_IDLE;
    if (at_end) begin
      f_emit = 1'b1;
    end else if (is_space) begin
      f_emit = 1'b0;
    end else if (is_digit) begin
      f_mode = MODE_NUMBER;
      f_num  = 1'b1;
    end else begin
      case (ch)
        CH_PLUS: begin
          f_emit = 1'b1; f_tok = make_tok(KIND_ADD, VAR_PLUS, '0, 1'b0, ERR_NONE);
        end
        CH_MINUS: begin
          f_emit = 1'b1; f_tok = make_tok(KIND_ADD, VAR_MINUS, '0, 1'b0, ERR_NONE);
        end
        CH_STAR: begin
          f_emit = 1'b1; f_tok = make_tok(KIND_MUL, VAR_TIMES, '0, 1'b0, ERR_NONE);
        end
        CH_SLASH: begin
          f_emit = 1'b1; f_tok = make_tok(KIND_MUL, VAR_DIV, '0, 1'b0, ERR_NONE);
        end
        CH_LPAREN: begin
          f_emit = 1'b1; f_tok = make_tok(KIND_LPAREN, VAR_NONE, '0, 1'b0, ERR_NONE);
        end
        CH_RPAREN: begin
          f_emit = 1'b1; f_tok = make_tok(KIND_RPAREN, VAR_NONE, '0, 1'b0, ERR_NONE);
        end
        CH_LESS:  f_mode = MODE_LT;
        CH_GREAT: f_mode = MODE_GT;
        CH_AMP:   f_mode = MODE_AMP;
        CH_EQUAL: f_mode = MODE_EQ;
        CH_PIPE:  f_mode = MODE_PIPE;
        CH_BANG:  f_mode = MODE_BANG;
        CH_T, CH_F: begin
          f_mode = MODE_KEYWORD;
          f_kw   = 1'b1;
        end
        default: begin
          f_emit = 1'b1;
          f_tok  = make_tok(KIND_ERROR, VAR_NONE, '0, 1'b0, ERR_BAD_CHAR);
          f_mode = MODE_ERROR;
        end
      endcase
    end
  end

  always_comb begin
    mode_next   = mode;
    acc_next    = acc;
    sat_next    = sat;
    kpos_next   = kpos;
    kmis_next   = kmis;
    kfalse_next = kfalse;
    c_emit      = 1'b0;
    s_emit      = 1'b0;
    use_fresh   = 1'b0;
    c_tok       = make_tok(KIND_EOF, VAR_NONE, '0, 1'b0, ERR_NONE);
    s_tok       = make_tok(KIND_EOF, VAR_NONE, '0, 1'b0, ERR_NONE);
    klen        = kfalse ? LEN_FALSE : LEN_TRUE;
    kerr        = kfalse ? ERR_WANT_FALSE : ERR_WANT_TRUE;
    kmis_w      = kmis | (ch != keyword_char(kfalse, kpos));
    kpos_w      = kpos + 3'd1;

    case (mode)
      MODE_NUMBER: begin
        if (!at_end && is_digit) begin
          if (prod_ovf) begin
            acc_next = '1;
            sat_next = 1'b1;
          end else begin
            acc_next = prod[VALUE_WIDTH-1:0];
          end
        end else begin
          c_emit    = 1'b1;
          c_tok     = make_tok(KIND_LIT, VAR_INT, OUT_VALUE_W'(acc), sat, ERR_NONE);
          acc_next  = '0;
          sat_next  = 1'b0;
          use_fresh = 1'b1;
        end
      end
      MODE_LT, MODE_GT: begin
        c_emit = 1'b1;
        if (!at_end && ch == CH_EQUAL) begin
          c_tok = make_tok(KIND_REL, (mode == MODE_LT) ? VAR_LE : VAR_GE, '0, 1'b0,
                           ERR_NONE);
          mode_next = MODE_IDLE;
        end else begin
          c_tok = make_tok(KIND_REL, (mode == MODE_LT) ? VAR_LT : VAR_GT, '0, 1'b0,
                           ERR_NONE);
          use_fresh = 1'b1;
        end
      end
      MODE_AMP, MODE_EQ, MODE_PIPE, MODE_BANG: begin
        c_emit = 1'b1;
        if (!at_end && mode == MODE_AMP && ch == CH_AMP) begin
          c_tok = make_tok(KIND_AND, VAR_NONE, '0, 1'b0, ERR_NONE);
          mode_next = MODE_IDLE;
        end else if (!at_end && mode == MODE_EQ && ch == CH_EQUAL) begin
          c_tok = make_tok(KIND_EQU, VAR_EQ, '0, 1'b0, ERR_NONE);
          mode_next = MODE_IDLE;
        end else if (!at_end && mode == MODE_PIPE && ch == CH_PIPE) begin
          c_tok = make_tok(KIND_OR, VAR_NONE, '0, 1'b0, ERR_NONE);
          mode_next = MODE_IDLE;
        end else if (!at_end && mode == MODE_BANG && ch == CH_EQUAL) begin
          c_tok = make_tok(KIND_EQU, VAR_NE, '0, 1'b0, ERR_NONE);
          mode_next = MODE_IDLE;
        end else begin
          // broken pair: the byte is dropped, not lexed
          c_tok = make_tok(KIND_ERROR, VAR_NONE, '0, 1'b0,
                           (mode == MODE_AMP)  ? ERR_WANT_AND :
                           (mode == MODE_EQ)   ? ERR_WANT_EQ  :
                           (mode == MODE_PIPE) ? ERR_WANT_OR  : ERR_WANT_NE);
          s_emit    = at_end;
          mode_next = at_end ? MODE_IDLE : MODE_ERROR;
        end
      end
      MODE_KEYWORD: begin
        if (at_end) begin
          c_emit    = 1'b1;
          c_tok     = make_tok(KIND_ERROR, VAR_NONE, '0, 1'b0, kerr);
          s_emit    = 1'b1;
          mode_next = MODE_IDLE;
        end else begin
          // every byte counts toward the keyword length, match or not
          kpos_next = kpos_w;
          kmis_next = kmis_w;
          if (kpos_w >= klen) begin
            kpos_next = '0;
            kmis_next = 1'b0;
            c_emit    = 1'b1;
            if (kmis_w) begin
              c_tok     = make_tok(KIND_ERROR, VAR_NONE, '0, 1'b0, kerr);
              mode_next = MODE_ERROR;
            end else begin
              c_tok     = make_tok(KIND_LIT, kfalse ? VAR_FALSE : VAR_TRUE, '0, 1'b0,
                                   ERR_NONE);
              mode_next = MODE_IDLE;
            end
          end
        end
      end
      MODE_ERROR: begin
        if (at_end) begin
          c_emit    = 1'b1;
          mode_next = MODE_IDLE;
        end
      end
      default: use_fresh = 1'b1;
    endcase

    if (use_fresh) begin
      s_emit    = f_emit;
      s_tok     = f_tok;
      mode_next = f_mode;
      if (f_num) begin
        acc_next = VALUE_WIDTH'(ch[3:0]);
        sat_next = 1'b0;
      end
      if (f_kw) begin
        kpos_next   = 3'd1;
        kmis_next   = 1'b0;
        kfalse_next = (ch == CH_F);
      end
    end

    if (c_emit) begin
      res0  = c_tok;
      res1  = s_tok;
      count = s_emit ? 2'd2 : 2'd1;
    end else begin
      res0  = s_tok;
      res1  = s_tok;
      count = s_emit ? 2'd1 : 2'd0;
    end
    res0.last = (count == 2'd1);
    res1.last = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode   <= MODE_IDLE;
      acc    <= '0;
      sat    <= 1'b0;
      kpos   <= '0;
      kmis   <= 1'b0;
      kfalse <= 1'b0;
    end else if (step) begin
      mode   <= mode_next;
      acc    <= acc_next;
      sat    <= sat_next;
      kpos   <= kpos_next;
      kmis   <= kmis_next;
      kfalse <= kfalse_next;
    end
  end

endmodule

// ===== src/exptok_outbuf.sv =====
// Two-slot result buffer: head slot drives the output, a spare slot
// holds the second token of a byte. Depends on exptok_pkg.
module exptok_outbuf (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  input  logic [1:0]         count,
  input  exptok_pkg::token_t res0,
  input  exptok_pkg::token_t res1,
  output logic               take,
  output logic               out_valid,
  input  logic               out_ready,
  output exptok_pkg::token_t out_tok
);
  import exptok_pkg::*;

  logic   head_vld, spare_vld;
  token_t head, spare;
  logic   pop;

  assign pop       = head_vld && out_ready;
  // a byte is lexed only when both its tokens are sure to fit
  assign take      = item_valid && !spare_vld && (!head_vld || pop);
  assign out_valid = head_vld;
  assign out_tok   = head;

  always_ff @(posedge clk) begin
    if (rst) begin
      head_vld  <= 1'b0;
      spare_vld <= 1'b0;
    end else if (spare_vld) begin
      if (pop) begin
        head      <= spare;
        spare_vld <= 1'b0;
      end
    end else if (take) begin
      case (count)
        2'd1: begin
          head     <= res0;
          head_vld <= 1'b1;
        end
        2'd2: begin
          head      <= res0;
          spare     <= res1;
          head_vld  <= 1'b1;
          spare_vld <= 1'b1;
        end
        default: head_vld <= head_vld && !pop;
      endcase
    end else if (pop) begin
      head_vld <= 1'b0;
    end
  end

endmodule

// ===== src/expression_tokenizer_core.sv =====
// Expression tokenizer top level: input register, lexer, result buffer.
// Depends on exptok_pkg, exptok_lexer and exptok_outbuf.
//
//   channel | handshake            | words
//   in      | in_valid / in_ready  | ch, end_of_text
//   out     | out_valid / out_ready| kind, variant, value, overflow, error_code, last
//
// A byte is lexed from the input register when the result buffer takes it;
// its tokens are registered in the result buffer and drive the output from
// there. One byte per cycle sustained while out_ready stays high; a byte that
// yields two tokens holds the next byte while the spare token drains.
// Output stalls back up through the result buffer to in_ready.
// Synchronous reset returns the lexer to idle with empty buffers.
module expression_tokenizer_core #(
  parameter int VALUE_WIDTH = exptok_pkg::VALUE_WIDTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [7:0]           ch,
  input  logic                 end_of_text,
  output logic                 out_valid,
  input  logic                 out_ready,
  output exptok_pkg::kind_t    kind,
  output logic [1:0]           variant,
  output logic [31:0]          value,
  output logic                 overflow,
  output exptok_pkg::err_t     error_code,
  output logic                 last
);
  import exptok_pkg::*;

  logic       in_vld;
  logic [7:0] ch_q;
  logic       eot_q;
  logic       at_end;
  logic       take;
  logic [1:0] count;
  token_t     res0, res1, out_tok;

  assign in_ready = !in_vld || take;
  assign at_end   = eot_q || (ch_q == CH_NUL);

  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else if (in_ready) begin
      in_vld <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      ch_q  <= ch;
      eot_q <= end_of_text;
    end
  end

  exptok_lexer #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_lexer (
    .clk    (clk),
    .rst    (rst),
    .step   (take),
    .ch     (ch_q),
    .at_end (at_end),
    .count  (count),
    .res0   (res0),
    .res1   (res1)
  );

  exptok_outbuf u_outbuf (
    .clk        (clk),
    .rst        (rst),
    .item_valid (in_vld),
    .count      (count),
    .res0       (res0),
    .res1       (res1),
    .take       (take),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_tok    (out_tok)
  );

  assign kind       = out_tok.kind;
  assign variant    = out_tok.variant;
  assign value      = out_tok.value;
  assign overflow   = out_tok.overflow;
  assign error_code = out_tok.error_code;
  assign last       = out_tok.last;

endmodule
